/* sv/zwfr_pkg.sv */
// Shared types and constants of the Z-Wave frame receiver.
package zwfr_pkg;

	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 7;

	localparam logic [CFG_IDX_W-1:0] REG_RECEIVE_ENABLE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INVERT_BYTES   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH     = 2'd2;

	localparam logic [7:0] XOR_SEED       = 8'hff;
	localparam logic [7:0] LEN_INDEX      = 8'd7;
	localparam logic [7:0] MIN_LEN        = 8'd8;
	localparam logic [6:0] MAX_LENGTH_RST = 7'd60;

	typedef enum logic [1:0] {
		ST_RECV,
		ST_PRIME,
		ST_SHOW
	} state_t;

	typedef struct packed {
		logic take;
		logic rd_first;
		logic rd_next;
	} cmd_t;

	typedef struct packed {
		logic frame_ok;
		logic rd_last;
	} status_t;

endpackage

/* sv/zwfr_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module zwfr_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* sv/zwfr_ctrl.sv */
// Controller: receive, prime the buffer read, stream the frame out.
module zwfr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	output logic              m_tvalid,
	input  logic              m_tready,
	input  zwfr_pkg::status_t status,
	output zwfr_pkg::cmd_t    cmd
);

	zwfr_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= zwfr_pkg::ST_RECV;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			zwfr_pkg::ST_RECV: begin
				if (cmd.take && status.frame_ok) begin
					state_d = zwfr_pkg::ST_PRIME;
				end
			end
			zwfr_pkg::ST_PRIME: begin
				state_d = zwfr_pkg::ST_SHOW;
			end
			zwfr_pkg::ST_SHOW: begin
				if (m_tready && status.rd_last) begin
					state_d = zwfr_pkg::ST_RECV;
				end
			end
			default: begin
				state_d = zwfr_pkg::ST_RECV;
			end
		endcase
	end

	always_comb begin
		s_tready     = 1'b0;
		m_tvalid     = 1'b0;
		cmd.take     = 1'b0;
		cmd.rd_first = 1'b0;
		cmd.rd_next  = 1'b0;
		unique case (state_q)
			zwfr_pkg::ST_RECV: begin
				s_tready = 1'b1;
				cmd.take = s_tvalid;
			end
			zwfr_pkg::ST_PRIME: begin
				cmd.rd_first = 1'b1;
			end
			zwfr_pkg::ST_SHOW: begin
				m_tvalid    = 1'b1;
				cmd.rd_next = m_tready && !status.rd_last;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

endmodule

/* sv/zwfr_dpath.sv */
// Datapath: config registers, frame tracking, checksum and frame buffer.
module zwfr_dpath #(
	parameter int unsigned MAX_FRAME = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	input  logic [zwfr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [zwfr_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic [7:0]                          raw_byte,
	input  logic                                packet_start,
	input  zwfr_pkg::cmd_t                      cmd,
	output zwfr_pkg::status_t                   status,
	output logic [7:0]                          frame_byte
);

	localparam int unsigned AW = $clog2(MAX_FRAME);
	localparam int unsigned CW = $clog2(MAX_FRAME + 1);
	localparam logic [7:0] MAX_FRAME_B = 8'(MAX_FRAME);

	logic          receive_enable_q;
	logic          invert_bytes_q;
	logic [6:0]    max_length_q;
	logic [CW-1:0] byte_count_q, byte_count_d;
	logic [CW-1:0] frame_length_q, frame_length_d;
	logic [7:0]    running_xor_q, running_xor_d;
	logic          frame_dead_q, frame_dead_d;
	logic [AW-1:0] rd_addr_q;
	logic [AW-1:0] raddr;

	logic          live;
	logic [CW-1:0] count_eff;
	logic [7:0]    xor_eff;
	logic          dead_eff;
	logic [7:0]    data_b;
	logic [7:0]    limit;
	logic          at_len;
	logic          len_bad;
	logic [CW-1:0] len_eff;
	logic [CW-1:0] count_inc;
	logic          complete;
	logic          we;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			receive_enable_q <= 1'b0;
			invert_bytes_q   <= 1'b1;
			max_length_q     <= zwfr_pkg::MAX_LENGTH_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				zwfr_pkg::REG_RECEIVE_ENABLE: receive_enable_q <= cfg_data[0];
				zwfr_pkg::REG_INVERT_BYTES:   invert_bytes_q   <= cfg_data[0];
				zwfr_pkg::REG_MAX_LENGTH:     max_length_q     <= cfg_data;
				default:                      max_length_q     <= max_length_q;
			endcase
		end
	end

	always_comb begin
		live      = cmd.take && receive_enable_q;
		count_eff = packet_start ? '0 : byte_count_q;
		xor_eff   = packet_start ? zwfr_pkg::XOR_SEED : running_xor_q;
		dead_eff  = packet_start ? 1'b0 : frame_dead_q;
		data_b    = invert_bytes_q ? ~raw_byte : raw_byte;
		limit     = ({1'b0, max_length_q} > MAX_FRAME_B) ? MAX_FRAME_B
		                                                 : {1'b0, max_length_q};
		at_len    = (8'(count_eff) == zwfr_pkg::LEN_INDEX);
		len_bad   = at_len && ((data_b < zwfr_pkg::MIN_LEN) || (data_b > limit));
		len_eff   = at_len ? CW'(data_b) : frame_length_q;
		count_inc = count_eff + CW'(1);
		complete  = (8'(count_inc) >= zwfr_pkg::MIN_LEN) && (count_inc == len_eff);

		byte_count_d   = byte_count_q;
		frame_length_d = frame_length_q;
		running_xor_d  = running_xor_q;
		frame_dead_d   = frame_dead_q;
		we             = 1'b0;
		status.frame_ok = 1'b0;
		status.rd_last  = ((CW'(rd_addr_q) + CW'(1)) == frame_length_q);

		if (live) begin
			byte_count_d  = count_eff;
			running_xor_d = xor_eff;
			frame_dead_d  = dead_eff;
			if (!dead_eff) begin
				if (8'(count_eff) >= MAX_FRAME_B) begin
					frame_dead_d = 1'b1;
				end else begin
					we = 1'b1;
					if (len_bad) begin
						frame_dead_d = 1'b1;
					end else begin
						frame_length_d = len_eff;
						byte_count_d   = count_inc;
						if (complete) begin
							frame_dead_d    = 1'b1;
							status.frame_ok = (xor_eff == data_b);
						end else begin
							running_xor_d = xor_eff ^ data_b;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q   <= '0;
			frame_length_q <= '0;
			running_xor_q  <= zwfr_pkg::XOR_SEED;
			frame_dead_q   <= 1'b1;
			rd_addr_q      <= '0;
		end else begin
			byte_count_q   <= byte_count_d;
			frame_length_q <= frame_length_d;
			running_xor_q  <= running_xor_d;
			frame_dead_q   <= frame_dead_d;
			if (cmd.rd_first || cmd.rd_next) begin
				rd_addr_q <= raddr;
			end
		end
	end

	assign raddr = cmd.rd_first ? '0 : rd_addr_q + AW'(1);

	zwfr_ram #(
		.WIDTH(8),
		.DEPTH(MAX_FRAME)
	) u_frame_store (
		.clk  (clk),
		.we   (we),
		.waddr(count_eff[AW-1:0]),
		.wdata(data_b),
		.re   (cmd.rd_first || cmd.rd_next),
		.raddr(raddr),
		.rdata(frame_byte)
	);

endmodule

/* sv/zwave_frame_receiver.sv */
// Z-Wave frame receiver: a byte stream in, checksum-validated frames out.
// Input bytes are taken one per cycle while the block is receiving. When the
// byte that completes a frame arrives with a matching XOR checksum, input
// stalls: a prime state starts reading the frame buffer, then one byte per cycle
// goes out on the output (longer if the sink stalls), set by the single read port
// of the frame buffer. Input stays blocked until the last byte leaves. Failed
// frames cost nothing. The config port takes a write in every cycle.
module zwave_frame_receiver #(
	parameter int unsigned MAX_FRAME = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [zwfr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [zwfr_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [7:0]                          s_tdata,   // raw_byte
	input  logic                                s_tuser,   // packet_start
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [7:0]                          m_tdata,   // frame_byte
	output logic                                m_tlast    // last_byte
);

	zwfr_pkg::cmd_t    cmd;
	zwfr_pkg::status_t status;

	assign cfg_ready = 1'b1;
	assign m_tlast   = status.rd_last;

	zwfr_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.status  (status),
		.cmd     (cmd)
	);

	zwfr_dpath #(
		.MAX_FRAME(MAX_FRAME)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.raw_byte    (s_tdata),
		.packet_start(s_tuser),
		.cmd         (cmd),
		.status      (status),
		.frame_byte  (m_tdata)
	);

endmodule

/* sv/zwfr_checker.sv */
// Port-level checks of the frame receiver and their binding.
module zwfr_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tlast
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output changed while stalled");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input taken during frame readout");

	a_frame_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast |=> !m_tvalid && s_tready)
		else $error("readout did not end after last byte");

	a_start_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
		else $error("readout started without a completing input transfer");

endmodule

bind zwave_frame_receiver zwfr_checker u_zwfr_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tlast (m_tlast)
);

/* sim/zwave_frame_receiver_tb.sv */
// Self-checking testbench for the Z-Wave frame receiver: random frames against a checksum model.
`timescale 1ns / 1ps

module zwave_frame_receiver_tb;

	localparam int MAX_FRAME   = 64;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE      = 100;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct packed {
		logic [7:0] data;
		logic       start;
	} rx_byte_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} frame_byte_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [zwfr_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [zwfr_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic                            s_tvalid = 1'b0;
	logic                            s_tready;
	logic [7:0]                      s_tdata = '0;
	logic                            s_tuser = 1'b0;
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	logic [7:0]                      m_tdata;
	logic                            m_tlast;

	zwave_frame_receiver #(.MAX_FRAME(MAX_FRAME)) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	// receiver model state and its copy of the registers
	logic       rx_enable = 1'b0;
	logic       rx_invert = 1'b1;
	logic [6:0] rx_max_len = zwfr_pkg::MAX_LENGTH_RST;
	logic [7:0] frame_img [MAX_FRAME];
	logic [6:0] byte_cnt = '0;
	logic [6:0] frame_len = '0;
	logic [7:0] run_xor = zwfr_pkg::XOR_SEED;
	bit         frame_dead = 1'b1;

	rx_byte_t    rx_pending[$];
	frame_byte_t frame_expect[$];

	int n_queued = 0;
	int n_taken = 0;
	int n_checked = 0;
	int n_frames = 0;
	int n_err = 0;
	int cyc = 0;
	int src_gap_pct = 29;
	int snk_gap_pct = 29;
	bit hold_go = 1'b0;
	bit hold_seen = 1'b0;
	int hold_left = 0;

	initial begin
		forever #2 clk = ~clk;
	end

	task automatic take_byte(input rx_byte_t it);
		logic [7:0] b;
		int lim;
		if (!rx_enable)
			return;
		if (it.start) begin
			byte_cnt = '0;
			run_xor = zwfr_pkg::XOR_SEED;
			frame_dead = 1'b0;
		end
		if (frame_dead)
			return;
		b = rx_invert ? ~it.data : it.data;
		if (byte_cnt >= MAX_FRAME) begin
			frame_dead = 1'b1;
			return;
		end
		frame_img[byte_cnt[5:0]] = b;
		if (byte_cnt == zwfr_pkg::LEN_INDEX) begin
			lim = (rx_max_len > MAX_FRAME) ? MAX_FRAME : int'(rx_max_len);
			frame_len = b[6:0];
			if (b < zwfr_pkg::MIN_LEN || b > lim) begin
				frame_dead = 1'b1;
				return;
			end
		end
		byte_cnt = byte_cnt + 7'd1;
		if (byte_cnt >= zwfr_pkg::MIN_LEN && byte_cnt == frame_len) begin
			if (run_xor == b)
				for (int i = 0; i < frame_len; i++)
					frame_expect.push_back('{data: frame_img[i[5:0]],
						last: (i + 1 == frame_len)});
			frame_dead = 1'b1;
		end else begin
			run_xor = run_xor ^ b;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : feed
		rx_byte_t cur;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				take_byte('{data: s_tdata, start: s_tuser});
				n_taken++;
			end
			if (!s_tvalid || s_tready) begin
				if (rx_pending.size() != 0 && $urandom_range(99) >= src_gap_pct) begin
					cur = rx_pending.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= cur.data;
					s_tuser <= cur.start;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : drain
		frame_byte_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid === 1'b1 && m_tready) begin
				n_checked++;
				if (m_tlast === 1'b1)
					n_frames++;
				if (frame_expect.size() == 0) begin
					$display("%0t: output byte expected none actual %h last %b",
						$time, m_tdata, m_tlast);
					n_err++;
				end else begin
					want = frame_expect.pop_front();
					if (m_tdata !== want.data) begin
						$display("%0t: frame_byte expected %h actual %h",
							$time, want.data, m_tdata);
						n_err++;
					end
					if (m_tlast !== want.last) begin
						$display("%0t: last_byte expected %b actual %b",
							$time, want.last, m_tlast);
						n_err++;
					end
				end
			end
			if (hold_go != hold_seen) begin
				hold_seen = hold_go;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= snk_gap_pct);
			end
		end
	end

	always @(posedge clk) begin
		cyc++;
		if (cyc > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic cfg_write(input logic [zwfr_pkg::CFG_IDX_W-1:0] idx,
		input logic [zwfr_pkg::CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		cfg_valid <= 1'b0;
		case (idx)
			zwfr_pkg::REG_RECEIVE_ENABLE: rx_enable = val[0];
			zwfr_pkg::REG_INVERT_BYTES:   rx_invert = val[0];
			zwfr_pkg::REG_MAX_LENGTH:     rx_max_len = val;
			default: ;
		endcase
	endtask

	// wait until every byte is taken and every frame byte is out, then let the block drain
	task automatic settle();
		do @(posedge clk); while (n_taken != n_queued || frame_expect.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic push_byte(input logic [7:0] val, input logic start);
		rx_pending.push_back('{data: rx_invert ? ~val : val, start: start});
		n_queued++;
	endtask

	// len_byte goes to byte 7; the checksum is fixed up when nbytes matches it
	task automatic push_frame(input logic [7:0] len_byte, input int nbytes, input bit corrupt);
		logic [7:0] f [MAX_FRAME];
		logic [7:0] x;
		int c;
		for (int i = 0; i < nbytes; i++)
			f[i[5:0]] = 8'($urandom);
		if (nbytes > 7)
			f[7] = len_byte;
		if (nbytes >= 8 && nbytes == len_byte) begin
			c = (nbytes == 8) ? 6 : nbytes - 1;
			x = zwfr_pkg::XOR_SEED;
			for (int i = 0; i < nbytes - 1; i++)
				if (i != c)
					x = x ^ f[i[5:0]];
			if (nbytes == 8)
				f[6] = x ^ f[7];
			else
				f[6'(nbytes - 1)] = x;
		end
		if (corrupt)
			f[0] = f[0] ^ (8'h01 << $urandom_range(7));
		for (int i = 0; i < nbytes; i++)
			push_byte(f[i[5:0]], i == 0);
	endtask

	task automatic push_random_frame();
		int lim;
		int len;
		int pick;
		logic [7:0] lb;
		lim = (rx_max_len > MAX_FRAME) ? MAX_FRAME : int'(rx_max_len);
		if (lim >= 8)
			len = ($urandom_range(9) == 0) ? $urandom_range(lim, 8)
				: $urandom_range((lim < 16) ? lim : 16, 8);
		else
			len = $urandom_range(16, 8);
		pick = $urandom_range(99);
		if (pick < 62) begin
			push_frame(8'(len), len, 1'b0);
		end else if (pick < 74) begin
			push_frame(8'(len), len, 1'b1);
		end else if (pick < 84) begin
			if ($urandom_range(1) == 0 || lim >= 64)
				lb = 8'($urandom_range(7));
			else
				lb = 8'($urandom_range(255, lim + 1));
			if ($urandom_range(3) == 0)
				lb = 8'($urandom_range(255, 128));
			push_frame(lb, $urandom_range(12, 8), 1'b0);
		end else if (pick < 92) begin
			push_frame(8'(len), $urandom_range(len - 1, 1), 1'b0);
		end else begin
			repeat ($urandom_range(6, 1))
				push_byte(8'($urandom), $urandom_range(7) == 0);
		end
	endtask

	task automatic push_random(input int n);
		int goal;
		goal = n_queued + n;
		while (n_queued < goal)
			push_random_frame();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// receiver still disabled after reset: drop these
		push_byte(8'h00, 1'b1);
		push_byte(8'hff, 1'b0);
		settle();
		cfg_write(zwfr_pkg::REG_RECEIVE_ENABLE, 7'd1);

		push_byte(8'h5a, 1'b0);
		push_frame(8'd8, 3, 1'b0);
		push_frame(8'd8, 8, 1'b0);
		push_frame(8'd7, 8, 1'b0);
		push_byte(8'hff, 1'b0);
		settle();

		push_random(60);
		settle();

		cfg_write(zwfr_pkg::REG_INVERT_BYTES, 7'd0);
		cfg_write(zwfr_pkg::REG_MAX_LENGTH, 7'd64);
		hold_go = ~hold_go;
		push_frame(8'd12, 12, 1'b0);
		push_random(60);
		settle();

		// steady stretch: no gaps on either side
		src_gap_pct = 0;
		snk_gap_pct = 0;
		cfg_write(zwfr_pkg::REG_INVERT_BYTES, 7'd1);
		cfg_write(zwfr_pkg::REG_MAX_LENGTH, 7'd127);
		push_frame(8'd64, 64, 1'b0);
		push_frame(8'd65, 10, 1'b0);
		push_random(40);
		push_frame(8'd64, 64, 1'b0);
		settle();

		src_gap_pct = 29;
		snk_gap_pct = 29;
		cfg_write(zwfr_pkg::REG_INVERT_BYTES, 7'd0);
		cfg_write(zwfr_pkg::REG_MAX_LENGTH, 7'd8);
		push_frame(8'd9, 9, 1'b0);
		push_random(40);
		settle();

		cfg_write(zwfr_pkg::REG_MAX_LENGTH, 7'd0);
		push_random(30);
		settle();

		cfg_write(zwfr_pkg::REG_RECEIVE_ENABLE, 7'd0);
		cfg_write(zwfr_pkg::REG_MAX_LENGTH, 7'd60);
		push_random(30);
		settle();

		cfg_write(zwfr_pkg::REG_RECEIVE_ENABLE, 7'd1);
		cfg_write(zwfr_pkg::REG_INVERT_BYTES, 7'($urandom_range(1)));
		cfg_write(zwfr_pkg::REG_MAX_LENGTH, 7'($urandom_range(63, 9)));
		push_random(60);
		settle();

		if (frame_expect.size() != 0) begin
			$display("%0t: %0d frame bytes never arrived", $time, frame_expect.size());
			n_err++;
		end
		$display("Covered %0d input bytes and %0d output bytes in %0d frames,",
			n_taken, n_checked, n_frames);
		$display("over enable, inversion, length limits 0 to 127, gaps and a sink hold.");
		if (n_err == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
